>>> design/ubxpr_pkg.sv
// Shared types and constants for the UBX frame parser and responder.
// No dependencies; imported by every module of the block.
`default_nettype none
package ubxpr_pkg;

   localparam int MAX_PAYLOAD_DEFAULT = 64;
   localparam int QUEUE_DEPTH         = 2;
   localparam int CSR_INDEX_W         = 4;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_ANSWER_ENABLE = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_UTC_VALID     = 4'd1;

   // Frame bytes.
   localparam logic [7:0] SYNC_1       = 8'hB5;
   localparam logic [7:0] SYNC_2       = 8'h62;
   localparam logic [7:0] CLASS_NAV    = 8'h01;
   localparam logic [7:0] ID_TIMEUTC   = 8'h21;
   localparam logic [7:0] CLASS_CFG    = 8'h06;
   localparam logic [7:0] ID_PRT       = 8'h00;
   localparam logic [7:0] ID_CFG       = 8'h09;
   localparam logic [7:0] CLASS_ACK    = 8'h05;
   localparam logic [7:0] ID_ACK       = 8'h01;
   localparam logic [7:0] FLAGS_VALID  = 8'h07;
   localparam logic [7:0] FLAGS_NOTVAL = 8'h03;
   localparam logic [7:0] TIMEUTC_LEN  = 8'd20;
   localparam logic [7:0] ACK_LEN      = 8'd2;
   localparam logic [15:0] PRT_LEN     = 16'd20;

   // Commands handed from the parser to the responder.
   localparam logic [1:0] CMD_TIMEUTC = 2'd0;
   localparam logic [1:0] CMD_PRT     = 2'd1;
   localparam logic [1:0] CMD_CFG     = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] baud;
   } cmd_type;

endpackage
`default_nettype wire

>>> design/ubxpr_parser.sv
// Front end: byte-wise UBX frame parser with running Fletcher-8 check.
// Depends on ubxpr_pkg; pushes decoded commands into ubxpr_queue.
`default_nettype none
module ubxpr_parser import ubxpr_pkg::*; #(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       byte_valid,
   input  wire logic [7:0] byte_data,
   input  wire logic       answer_enable,
   output logic            push,
   output cmd_type         push_cmd
);
   localparam int IDX_W = $clog2(MAX_PAYLOAD);

   localparam logic [3:0] S_HUNT    = 4'd0;
   localparam logic [3:0] S_SYNC    = 4'd1;
   localparam logic [3:0] S_CLASS   = 4'd2;
   localparam logic [3:0] S_ID      = 4'd3;
   localparam logic [3:0] S_LEN0    = 4'd4;
   localparam logic [3:0] S_LEN1    = 4'd5;
   localparam logic [3:0] S_PAYLOAD = 4'd6;
   localparam logic [3:0] S_CKA     = 4'd7;
   localparam logic [3:0] S_CKB     = 4'd8;

   logic [3:0]       state_ff, state_in;
   logic [7:0]       class_ff, class_in, id_ff, id_in;
   logic [15:0]      len_ff, len_in;
   logic [7:0]       sum_a_ff, sum_a_in, sum_b_ff, sum_b_in;
   logic             ck_ok_ff, ck_ok_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [31:0]      baud_ff, baud_in;
   logic [7:0]       add_a;
   logic [IDX_W:0]   idx_next;
   logic [15:0]      len_full;

   assign add_a    = sum_a_ff + byte_data;
   assign idx_next = {1'b0, idx_ff} + 1'b1;
   assign len_full = {byte_data, len_ff[7:0]};

   always_comb begin
      state_in = state_ff;
      class_in = class_ff;
      id_in    = id_ff;
      len_in   = len_ff;
      sum_a_in = sum_a_ff;
      sum_b_in = sum_b_ff;
      ck_ok_in = ck_ok_ff;
      idx_in   = idx_ff;
      baud_in  = baud_ff;
      push     = 1'b0;
      push_cmd = '{kind: CMD_CFG, baud: baud_ff};
      if (byte_valid) begin
         unique case (state_ff)
            S_HUNT: begin
               if (byte_data == SYNC_1) state_in = S_SYNC;
            end
            S_SYNC: begin
               if (byte_data == SYNC_2) begin
                  state_in = S_CLASS;
                  sum_a_in = '0;
                  sum_b_in = '0;
                  ck_ok_in = 1'b0;
                  baud_in  = '0;
               end else if (byte_data != SYNC_1) begin
                  state_in = S_HUNT;
               end
            end
            S_CLASS, S_ID, S_LEN0, S_LEN1, S_PAYLOAD: begin
               sum_a_in = add_a;
               sum_b_in = sum_b_ff + add_a;
               unique case (state_ff)
                  S_CLASS: begin
                     class_in = byte_data;
                     state_in = S_ID;
                  end
                  S_ID: begin
                     id_in    = byte_data;
                     state_in = S_LEN0;
                  end
                  S_LEN0: begin
                     len_in   = {len_ff[15:8], byte_data};
                     state_in = S_LEN1;
                  end
                  S_LEN1: begin
                     len_in = len_full;
                     idx_in = '0;
                     if (len_full > 16'(MAX_PAYLOAD)) state_in = S_HUNT;
                     else if (len_full == 16'd0)      state_in = S_CKA;
                     else                             state_in = S_PAYLOAD;
                  end
                  default: begin
                     // Payload bytes 8 to 11 carry the baud rate, low byte first.
                     if (idx_ff >= IDX_W'(8) && idx_ff <= IDX_W'(11)) begin
                        unique case (idx_ff[1:0])
                           2'd0: baud_in[7:0]   = byte_data;
                           2'd1: baud_in[15:8]  = byte_data;
                           2'd2: baud_in[23:16] = byte_data;
                           default: baud_in[31:24] = byte_data;
                        endcase
                     end
                     idx_in = idx_next[IDX_W-1:0];
                     if (16'(idx_next) == len_ff) state_in = S_CKA;
                  end
               endcase
            end
            S_CKA: begin
               ck_ok_in = (byte_data == sum_a_ff);
               state_in = S_CKB;
            end
            S_CKB: begin
               state_in = S_HUNT;
               if (ck_ok_ff && byte_data == sum_b_ff && answer_enable) begin
                  if (class_ff == CLASS_NAV && id_ff == ID_TIMEUTC && len_ff == 16'd0) begin
                     push          = 1'b1;
                     push_cmd.kind = CMD_TIMEUTC;
                  end else if (class_ff == CLASS_CFG && id_ff == ID_PRT
                               && len_ff == PRT_LEN) begin
                     push          = 1'b1;
                     push_cmd.kind = CMD_PRT;
                  end else if (class_ff == CLASS_CFG && id_ff == ID_CFG) begin
                     push          = 1'b1;
                     push_cmd.kind = CMD_CFG;
                  end
               end
            end
            default: state_in = S_HUNT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_HUNT;
         class_ff <= '0;
         id_ff    <= '0;
         len_ff   <= '0;
         sum_a_ff <= '0;
         sum_b_ff <= '0;
         ck_ok_ff <= 1'b0;
         idx_ff   <= '0;
         baud_ff  <= '0;
      end else begin
         state_ff <= state_in;
         class_ff <= class_in;
         id_ff    <= id_in;
         len_ff   <= len_in;
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
         ck_ok_ff <= ck_ok_in;
         idx_ff   <= idx_in;
         baud_ff  <= baud_in;
      end
   end

   // A payload in progress never runs past the declared length.
   a_payload_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PAYLOAD) |-> (16'(idx_ff) < len_ff))
      else $error("payload index beyond frame length");

endmodule
`default_nettype wire

>>> design/ubxpr_queue.sv
// Short command queue between parser and responder.
// Depends on ubxpr_pkg for the command type.
`default_nettype none
module ubxpr_queue import ubxpr_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  cmd_type   push_cmd,
   output logic      in_ready,
   output logic      out_valid,
   output cmd_type   out_cmd,
   input  wire logic pop
);
   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   cmd_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign in_ready  = (count_ff != (PTR_W+1)'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = slot_ff[rd_ff];
   assign do_push   = push && in_ready;
   assign do_pop    = pop && out_valid;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ff + 1'b1;
      if (do_pop)  rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ff + 1'b1;
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_cmd;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (count_ff == (PTR_W+1)'(QUEUE_DEPTH)) && !pop |=> (count_ff == (PTR_W+1)'(QUEUE_DEPTH)))
      else $error("queue level changed while full without a pop");

endmodule
`default_nettype wire

>>> design/ubxpr_responder.sv
// Back end: builds response frames byte by byte into an output register.
// Depends on ubxpr_pkg; takes commands from ubxpr_queue.
`default_nettype none
module ubxpr_responder import ubxpr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        cmd_valid,
   input  cmd_type          cmd,
   output logic             cmd_pop,
   input  wire logic        utc_valid,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       tx_byte,
   output logic             last_byte,
   output logic             baud_switch,
   output logic [31:0]      new_baud,
   output logic [31:0]      save_count
);
   logic        active_ff, active_in;
   logic [1:0]  kind_ff, kind_in;
   logic [4:0]  idx_ff, idx_in;
   logic [7:0]  sum_a_ff, sum_a_in, sum_b_ff, sum_b_in;
   logic [31:0] baud_ff, baud_in, saves_ff, saves_in;
   logic        ovalid_ff, ovalid_in;
   logic [7:0]  obyte_ff;
   logic        olast_ff, oswitch_ff;
   logic [31:0] obaud_ff, osaves_ff;

   logic        emit;
   logic [7:0]  plen;
   logic [4:0]  last_idx, ck_idx;
   logic [7:0]  body_byte, cur_byte, add_a;
   logic        is_last;

   assign plen     = (kind_ff == CMD_TIMEUTC) ? TIMEUTC_LEN : ACK_LEN;
   assign ck_idx   = 5'(plen) + 5'd6;
   assign last_idx = 5'(plen) + 5'd7;
   assign is_last  = (idx_ff == last_idx);
   assign emit     = active_ff && (!ovalid_ff || rsp_ready);
   assign cmd_pop  = !active_ff && cmd_valid;
   assign add_a    = sum_a_ff + body_byte;

   // Header and payload bytes of the frame being sent.
   always_comb begin
      body_byte = 8'h00;
      unique case (idx_ff)
         5'd0: body_byte = SYNC_1;
         5'd1: body_byte = SYNC_2;
         5'd2: body_byte = (kind_ff == CMD_TIMEUTC) ? CLASS_NAV : CLASS_ACK;
         5'd3: body_byte = (kind_ff == CMD_TIMEUTC) ? ID_TIMEUTC : ID_ACK;
         5'd4: body_byte = plen;
         5'd6: body_byte = (kind_ff == CMD_TIMEUTC) ? 8'h00 : CLASS_CFG;
         5'd7: begin
            if (kind_ff == CMD_PRT)      body_byte = ID_PRT;
            else if (kind_ff == CMD_CFG) body_byte = ID_CFG;
            else                         body_byte = 8'h00;
         end
         5'd25: body_byte = utc_valid ? FLAGS_VALID : FLAGS_NOTVAL;
         default: body_byte = 8'h00;
      endcase
   end

   always_comb begin
      if (idx_ff == ck_idx)     cur_byte = sum_a_ff;
      else if (is_last)         cur_byte = sum_b_ff;
      else                      cur_byte = body_byte;
   end

   always_comb begin
      active_in = active_ff;
      kind_in   = kind_ff;
      idx_in    = idx_ff;
      sum_a_in  = sum_a_ff;
      sum_b_in  = sum_b_ff;
      baud_in   = baud_ff;
      saves_in  = saves_ff;
      ovalid_in = ovalid_ff && !rsp_ready;
      if (cmd_pop) begin
         active_in = 1'b1;
         kind_in   = cmd.kind;
         idx_in    = '0;
         sum_a_in  = '0;
         sum_b_in  = '0;
         if (cmd.kind == CMD_PRT) baud_in  = cmd.baud;
         if (cmd.kind == CMD_CFG) saves_in = saves_ff + 32'd1;
      end
      if (emit) begin
         ovalid_in = 1'b1;
         idx_in    = idx_ff + 5'd1;
         if (idx_ff >= 5'd2 && idx_ff < ck_idx) begin
            sum_a_in = add_a;
            sum_b_in = sum_b_ff + add_a;
         end
         if (is_last) active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         ovalid_ff <= 1'b0;
         baud_ff   <= '0;
         saves_ff  <= '0;
      end else begin
         active_ff <= active_in;
         ovalid_ff <= ovalid_in;
         baud_ff   <= baud_in;
         saves_ff  <= saves_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      idx_ff   <= idx_in;
      sum_a_ff <= sum_a_in;
      sum_b_ff <= sum_b_in;
      if (emit) begin
         obyte_ff   <= cur_byte;
         olast_ff   <= is_last;
         oswitch_ff <= is_last && (kind_ff == CMD_PRT);
         obaud_ff   <= baud_ff;
         osaves_ff  <= saves_ff;
      end
   end

   assign rsp_valid   = ovalid_ff;
   assign tx_byte     = obyte_ff;
   assign last_byte   = olast_ff;
   assign baud_switch = oswitch_ff;
   assign new_baud    = obaud_ff;
   assign save_count  = osaves_ff;

   a_switch_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && baud_switch |-> last_byte)
      else $error("baud switch flagged away from the final byte");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (idx_ff <= last_idx))
      else $error("response index past end of frame");

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> active_ff && idx_ff == 5'd0)
      else $error("command taken without starting a frame");

endmodule
`default_nettype wire

>>> design/ubx_frame_parser_responder.sv
// Top level of the UBX frame parser and responder.
// Depends on ubxpr_pkg, ubxpr_parser, ubxpr_queue and ubxpr_responder.
//
// Received serial bytes enter one per cycle on the req_ stream. The parser
// hunts for the sync pair B5 62, collects class, id, length and payload, and
// checks the Fletcher-8 sum as the bytes go by; frames longer than
// MAX_PAYLOAD are dropped after their length field. A valid frame that needs
// an answer (NAV-TIMEUTC poll, CFG-PRT, CFG-CFG) leaves a command in a
// two-entry queue, and the responder streams the answer out on rsp_, one
// byte per cycle while rsp_tready allows: 28 bytes for the time report,
// 10 for an acknowledge; the next command is loaded after a frame ends.
// Input bytes are taken every cycle unless the command queue is full, which
// can happen when answers are asked for faster than they can be sent.
// Every result carries the current baud and save count as they stand after
// its frame was handled; the final acknowledge byte of CFG-PRT raises
// rsp_tuser, meaning the line should switch to the new baud after it.
// Configuration writes on csr_ are always accepted and must only be made
// while no frame is in flight.
`default_nettype none
module ubx_frame_parser_responder import ubxpr_pkg::*; #(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,   // [7:0] rx_byte
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [71:0]                 rsp_tdata,   // [7:0] tx_byte, [39:8] new_baud,
                                                    // [71:40] save_count
   output logic                        rsp_tlast,
   output logic [0:0]                  rsp_tuser,   // [0] baud_switch
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic                   csr_data
);
   logic    answer_enable_ff, utc_valid_ff;
   logic    push, q_ready, q_valid, q_pop;
   cmd_type push_cmd, q_cmd;
   logic [7:0]  tx_byte;
   logic [31:0] new_baud, save_count;
   logic        last_byte, baud_switch;

   // Configuration registers; writes to unknown indexes are ignored.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         answer_enable_ff <= 1'b1;
         utc_valid_ff     <= 1'b0;
      end else if (csr_valid) begin
         if (csr_index == CSR_ANSWER_ENABLE) answer_enable_ff <= csr_data;
         if (csr_index == CSR_UTC_VALID)     utc_valid_ff     <= csr_data;
      end
   end

   // Bytes are held off whenever the command queue is full.
   assign req_tready = q_ready;

   ubxpr_parser #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_parser (
      .clock        (clock),
      .reset        (reset),
      .byte_valid   (req_tvalid && req_tready),
      .byte_data    (req_tdata),
      .answer_enable(answer_enable_ff),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   ubxpr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .in_ready (q_ready),
      .out_valid(q_valid),
      .out_cmd  (q_cmd),
      .pop      (q_pop)
   );

   ubxpr_responder u_responder (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_valid),
      .cmd        (q_cmd),
      .cmd_pop    (q_pop),
      .utc_valid  (utc_valid_ff),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .tx_byte    (tx_byte),
      .last_byte  (last_byte),
      .baud_switch(baud_switch),
      .new_baud   (new_baud),
      .save_count (save_count)
   );

   assign rsp_tdata = {save_count, new_baud, tx_byte};
   assign rsp_tlast = last_byte;
   assign rsp_tuser = baud_switch;

endmodule
`default_nettype wire
